@@ design/cle_pkg.sv @@
// Shared types, constants and helpers for the circular list engine.
package cle_pkg;

    // Pool size and stored value width.
    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;

    // Derived widths.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Fixed port field widths.
    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 16;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_TRAVERSE  = 3'd6,
        OP_CLEAR     = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // What the sequencer does with the current item once it is decoded.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_INS_FRONT,
        ACT_INS_END,
        ACT_INS_MID,
        ACT_DEL_FRONT,
        ACT_DEL_END,
        ACT_DEL_MID,
        ACT_TRAV,
        ACT_CLEAR
    } act_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_WALK_START,
        S_WALK,
        S_NEXT,
        S_TAKE_RD,
        S_TAKE,
        S_LINK_NEW,
        S_LINK_OLD,
        S_HEAD_RD,
        S_HEAD,
        S_GIVE,
        S_CLEAR,
        S_TRAV_RD,
        S_TRAV,
        S_FINISH
    } state_t;

    // Access request from the sequencer to the node pool.
    typedef struct packed {
        logic [IDX_W-1:0]      rd_addr;
        logic                  lnk_we;
        logic [IDX_W-1:0]      lnk_addr;
        logic [IDX_W-1:0]      lnk_data;
        logic                  val_we;
        logic [IDX_W-1:0]      val_addr;
        logic [VALUE_BITS-1:0] val_data;
    } pool_req_t;

    // One result item as produced by the sequencer.
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] value;
        logic [LEN_W-1:0]  length;
        logic              last;
    } res_t;

    // Narrow a signed input value to the stored width.
    function automatic logic [VALUE_BITS-1:0] to_store(input logic [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] s;
        logic signed [63:0]       ext;
        s   = v;
        ext = 64'(s);
        return ext[VALUE_BITS-1:0];
    endfunction

    // Sign-extend a stored value and return its low output bits.
    function automatic logic [DATA_W-1:0] from_store(input logic [VALUE_BITS-1:0] v);
        logic signed [VALUE_BITS-1:0] s;
        logic signed [63:0]           ext;
        s   = v;
        ext = 64'(s);
        return ext[DATA_W-1:0];
    endfunction

    // Successor of a node in the free chain after reset.
    function automatic logic [IDX_W-1:0] succ(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == IDX_W'(CAPACITY - 1))
        begin
            r = '0;
        end
        else
        begin
            r = IDX_W'(a + IDX_W'(1));
        end
        return r;
    endfunction

endpackage

@@ design/cle_pool.sv @@
// Node pool: value memory and next-link memory with registered reads.
module cle_pool
    import cle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pool_req_t             req,
    output logic [IDX_W-1:0]      link_q,
    output logic [VALUE_BITS-1:0] value_q
);

    logic [IDX_W-1:0]      link_mem  [CAPACITY];
    logic [VALUE_BITS-1:0] value_mem [CAPACITY];
    logic [CAPACITY-1:0]   lnk_vld_reg;
    logic [CAPACITY-1:0]   lnk_vld_next;

    // A link entry not yet written reads as its place in the reset free chain.
    always_comb
    begin
        lnk_vld_next = lnk_vld_reg;
        if (req.lnk_we)
        begin
            lnk_vld_next[req.lnk_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lnk_vld_reg <= '0;
        end
        else
        begin
            lnk_vld_reg <= lnk_vld_next;
        end
    end

    // Link memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (req.lnk_we)
        begin
            link_mem[req.lnk_addr] <= req.lnk_data;
        end
        if (lnk_vld_reg[req.rd_addr])
        begin
            link_q <= link_mem[req.rd_addr];
        end
        else
        begin
            link_q <= succ(req.rd_addr);
        end
    end

    // Value memory, read at the same address as the link memory.
    always_ff @(posedge clk)
    begin
        if (req.val_we)
        begin
            value_mem[req.val_addr] <= req.val_data;
        end
        value_q <= value_mem[req.rd_addr];
    end

endmodule

@@ design/cle_ctrl.sv @@
// Sequencer that walks the list and updates the pool one access per cycle.
module cle_ctrl
    import cle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       op,
    input  logic [DATA_W-1:0]     item_value,
    input  logic [POS_W-1:0]      position,
    output pool_req_t             req,
    input  logic [IDX_W-1:0]      link_q,
    input  logic [VALUE_BITS-1:0] value_q,
    output logic                  res_valid,
    output res_t                  res,
    input  logic                  res_take
);

    state_t state_reg, state_next;
    act_t   act_reg, act_next;
    act_t   dec_act;
    logic [ST_W-1:0] dec_st;

    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  prev_reg, prev_next;
    logic [IDX_W-1:0]  nxt_reg, nxt_next;
    logic [IDX_W-1:0]  node_reg, node_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;

    logic [POS_W:0] pos_x;
    logic [POS_W:0] cnt_x;
    logic           full;
    logic           accept;

    assign pos_x  = {1'b0, pos_reg};
    assign cnt_x  = (POS_W + 1)'(count_reg);
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign accept = in_valid && !in_stall;

    // Classify the captured item against the current list.
    always_comb
    begin
        dec_act = ACT_NONE;
        dec_st  = ST_DONE;
        if (op_reg inside {OP_INS_FRONT, OP_INS_END, OP_INS_POS})
        begin
            if (full)
            begin
                dec_st = ST_FULL;
            end
            else if (op_reg == OP_INS_FRONT ||
                     (op_reg == OP_INS_POS && pos_x == (POS_W + 1)'(1)))
            begin
                dec_act = ACT_INS_FRONT;
            end
            else if (op_reg == OP_INS_END || pos_x == cnt_x + (POS_W + 1)'(1))
            begin
                dec_act = ACT_INS_END;
            end
            else if (pos_x == '0 || pos_x > cnt_x + (POS_W + 1)'(1))
            begin
                dec_st = ST_BAD;
            end
            else
            begin
                dec_act = ACT_INS_MID;
            end
        end
        else if (op_reg inside {OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS})
        begin
            if (count_reg == '0)
            begin
                dec_st = ST_BAD;
            end
            else if (op_reg == OP_DEL_FRONT ||
                     (op_reg == OP_DEL_POS && pos_x == (POS_W + 1)'(1)))
            begin
                dec_act = ACT_DEL_FRONT;
            end
            else if (op_reg == OP_DEL_END || pos_x == cnt_x)
            begin
                dec_act = ACT_DEL_END;
            end
            else if (pos_x == '0 || pos_x > cnt_x)
            begin
                dec_st = ST_BAD;
            end
            else
            begin
                dec_act = ACT_DEL_MID;
            end
        end
        else if (op_reg == OP_TRAVERSE)
        begin
            if (count_reg == '0)
            begin
                dec_st = ST_BAD;
            end
            else
            begin
                dec_act = ACT_TRAV;
            end
        end
        else
        begin
            if (count_reg != '0)
            begin
                dec_act = ACT_CLEAR;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (dec_act)
                    ACT_INS_FRONT, ACT_INS_END: state_next = S_TAKE_RD;
                    ACT_INS_MID, ACT_DEL_MID:   state_next = S_WALK_START;
                    ACT_DEL_FRONT:
                        state_next = (count_reg > CNT_W'(1)) ? S_HEAD_RD : S_GIVE;
                    ACT_DEL_END:
                        state_next = (count_reg > CNT_W'(1)) ? S_WALK_START : S_GIVE;
                    ACT_TRAV:                   state_next = S_TRAV_RD;
                    ACT_CLEAR:                  state_next = S_CLEAR;
                    default:                    state_next = S_FINISH;
                endcase
            end
            S_WALK_START: state_next = S_WALK;
            S_WALK:
            begin
                if (steps_reg == '0)
                begin
                    case (act_reg)
                        ACT_INS_MID: state_next = S_TAKE_RD;
                        ACT_DEL_MID: state_next = S_NEXT;
                        default:     state_next = S_GIVE;
                    endcase
                end
            end
            S_NEXT:       state_next = S_GIVE;
            S_TAKE_RD:    state_next = S_TAKE;
            S_TAKE:       state_next = S_LINK_NEW;
            S_LINK_NEW:
            begin
                if (act_reg != ACT_INS_MID && count_reg == CNT_W'(1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_LINK_OLD;
                end
            end
            S_LINK_OLD:   state_next = S_FINISH;
            S_HEAD_RD:    state_next = S_HEAD;
            S_HEAD:       state_next = S_GIVE;
            S_GIVE:       state_next = S_FINISH;
            S_CLEAR:      state_next = S_FINISH;
            S_TRAV_RD:    state_next = S_TRAV;
            S_TRAV:
            begin
                if (res_take && steps_reg == CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_FINISH:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // Pool accesses and result presentation.
    always_comb
    begin
        req          = '0;
        req.rd_addr  = cur_reg;
        req.val_addr = free_reg;
        req.val_data = to_store(val_reg);
        res_valid    = 1'b0;
        res.status   = st_reg;
        res.value    = '0;
        res.length   = LEN_W'(count_reg);
        res.last     = 1'b1;
        case (state_reg)
            S_WALK_START: req.rd_addr = head_reg;
            S_WALK:
            begin
                req.rd_addr = link_q;
                if (steps_reg == '0 && act_reg == ACT_DEL_END)
                begin
                    req.lnk_we   = 1'b1;
                    req.lnk_addr = cur_reg;
                    req.lnk_data = head_reg;
                end
            end
            S_NEXT:
            begin
                req.lnk_we   = 1'b1;
                req.lnk_addr = prev_reg;
                req.lnk_data = link_q;
            end
            S_TAKE_RD:    req.rd_addr = free_reg;
            S_TAKE:       req.val_we  = 1'b1;
            S_LINK_NEW:
            begin
                req.lnk_we   = 1'b1;
                req.lnk_addr = node_reg;
                if (act_reg == ACT_INS_MID)
                begin
                    req.lnk_data = nxt_reg;
                end
                else if (count_reg == CNT_W'(1))
                begin
                    req.lnk_data = node_reg;
                end
                else
                begin
                    req.lnk_data = head_reg;
                end
            end
            S_LINK_OLD:
            begin
                req.lnk_we   = 1'b1;
                req.lnk_addr = (act_reg == ACT_INS_MID) ? prev_reg : tail_reg;
                req.lnk_data = node_reg;
            end
            S_HEAD_RD:    req.rd_addr = head_reg;
            S_HEAD:
            begin
                req.lnk_we   = 1'b1;
                req.lnk_addr = tail_reg;
                req.lnk_data = link_q;
            end
            S_GIVE:
            begin
                req.lnk_we   = 1'b1;
                req.lnk_addr = node_reg;
                req.lnk_data = free_reg;
            end
            S_CLEAR:
            begin
                req.lnk_we   = 1'b1;
                req.lnk_addr = tail_reg;
                req.lnk_data = free_reg;
            end
            S_TRAV:
            begin
                res_valid   = 1'b1;
                res.status  = ST_DONE;
                res.value   = from_store(value_q);
                res.last    = (steps_reg == CNT_W'(1));
                req.rd_addr = res_take ? link_q : cur_reg;
            end
            S_FINISH:     res_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        act_next   = act_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        st_next    = st_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        nxt_next   = nxt_reg;
        node_next  = node_reg;
        steps_next = steps_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op;
                    val_next = item_value;
                    pos_next = position;
                end
            end
            S_DECODE:
            begin
                act_next  = dec_act;
                st_next   = dec_st;
                cur_next  = head_reg;
                node_next = (dec_act == ACT_DEL_END) ? tail_reg : head_reg;
                case (dec_act)
                    ACT_INS_MID, ACT_DEL_MID:
                        steps_next = CNT_W'(pos_reg - POS_W'(2));
                    ACT_DEL_END: steps_next = CNT_W'(count_reg - CNT_W'(2));
                    ACT_TRAV:    steps_next = count_reg;
                    default:     steps_next = '0;
                endcase
            end
            S_WALK_START: cur_next = head_reg;
            S_WALK:
            begin
                if (steps_reg == '0)
                begin
                    prev_next = cur_reg;
                    case (act_reg)
                        ACT_INS_MID: nxt_next  = link_q;
                        ACT_DEL_MID: node_next = link_q;
                        default:     tail_next = cur_reg;
                    endcase
                end
                else
                begin
                    cur_next   = link_q;
                    steps_next = steps_reg - CNT_W'(1);
                end
            end
            S_TAKE:
            begin
                free_next  = link_q;
                node_next  = free_reg;
                count_next = count_reg + CNT_W'(1);
            end
            S_LINK_NEW:
            begin
                if (act_reg != ACT_INS_MID && count_reg == CNT_W'(1))
                begin
                    head_next = node_reg;
                    tail_next = node_reg;
                end
            end
            S_LINK_OLD:
            begin
                if (act_reg == ACT_INS_END)
                begin
                    tail_next = node_reg;
                end
                else if (act_reg == ACT_INS_FRONT)
                begin
                    head_next = node_reg;
                end
            end
            S_HEAD:       head_next = link_q;
            S_GIVE:
            begin
                free_next  = node_reg;
                count_next = count_reg - CNT_W'(1);
            end
            S_CLEAR:
            begin
                free_next  = head_reg;
                count_next = '0;
            end
            S_TRAV:
            begin
                if (res_take)
                begin
                    cur_next   = link_q;
                    steps_next = steps_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state and list pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= ACT_NONE;
            st_reg    <= ST_DONE;
            head_reg  <= '0;
            tail_reg  <= '0;
            free_reg  <= '0;
            count_reg <= '0;
            steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            st_reg    <= st_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            steps_reg <= steps_next;
        end
    end

    // Item payload and walk pointers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        val_reg  <= val_next;
        pos_reg  <= pos_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        nxt_reg  <= nxt_next;
        node_reg <= node_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    // The list never holds more nodes than the pool has.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("node count beyond pool size");

    // Taking a node from the free chain adds exactly one to the count.
    a_take_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAKE |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("take did not add one node");

    // The final result of an item returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_take && res.last |=> state_reg == S_IDLE)
        else $error("sequencer busy after final result");

    // A pool-full report is only given when the pool really is full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && st_reg == ST_FULL |-> full)
        else $error("pool full reported with free nodes");

endmodule

@@ design/circular_list_engine_unit.sv @@
// Top level of the circular list engine: sequencer, node pool and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | in_valid, in_stall | op, item_value, position
//  output  | out       | out_valid,out_stall| status, node_value, list_length, last
//
// One item is worked at a time; in_stall is high from acceptance until the last result
// of the item is moved into the output register. Each step is one pool access per cycle.
// Mid-list inserts and deletes, and end deletes on a list of more than one node, walk the
// links from the head; a traverse gives one result per node. Reset clears the pointers
// and count at once; the link memory reads as the free chain until written, so no
// clearing pass is needed. Output stalls hold the sequencer in place without losing or
// repeating a result.
module circular_list_engine_unit
    import cle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [DATA_W-1:0] item_value,
    input  logic [POS_W-1:0]  position,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ST_W-1:0]   status,
    output logic [DATA_W-1:0] node_value,
    output logic [LEN_W-1:0]  list_length,
    output logic              last
);

    pool_req_t             req;
    logic [IDX_W-1:0]      link_q;
    logic [VALUE_BITS-1:0] value_q;
    logic                  res_valid;
    res_t                  res;
    logic                  res_take;

    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    cle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .item_value (item_value),
        .position   (position),
        .req        (req),
        .link_q     (link_q),
        .value_q    (value_q),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    cle_pool u_pool (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .link_q  (link_q),
        .value_q (value_q)
    );

    // A result moves into the output register when it is empty or being drained.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_res_next   = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign node_value  = out_res_reg.value;
    assign list_length = out_res_reg.length;
    assign last        = out_res_reg.last;

endmodule
